// ===== src/mlqs_pkg.sv =====
// Shared types and constants for the multilevel queue scheduler.
package mlqs_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] arrival_time;
    logic [7:0]  burst_time;
    logic [1:0]  level;
  } req_t;

  typedef struct packed {
    logic [15:0] slot_time;
    logic [3:0]  job_index;
    logic        idle;
    logic        finished;
    logic        all_done;
  } rsp_t;

  localparam logic [7:0] QuantumReset = 8'd2;

endpackage

// ===== src/multilevel_queue_scheduler.sv =====
// Top level of the multilevel queue scheduler: job table, scan sequencer and result register.
//
// Usage: requests arrive on req_valid_i/req_ready_o with a req_t payload.
// A load request stores one job record (dropped when the table is full) and
// a clear request empties the table; neither gives a response. A tick
// request runs one time unit and gives one rsp_t on rsp_valid_o/rsp_ready_o.
// The user must write the quantum register on cfg_valid_i/cfg_ready_o only while idle;
// the block does not enforce it. A load or clear leaves the sequencer idle, so they can
// follow back to back. With J jobs loaded, the table is walked one entry a cycle by a
// single comparator, in separate walks: once to admit level-one jobs, once to pick the
// winning level and level-two or level-three candidate, once to test whether all jobs are
// done, and once more after a slice ends to admit again. The response of a
// tick is written to the output register in the last state, and a new
// request is taken only once the sequencer is back in idle.
// After reset the table is empty, time is zero and the quantum is 2.
// A response waits in its output register while the receiver stalls; the
// next request is still taken and worked, but its response holds the
// sequencer until the output register is free.
module multilevel_queue_scheduler #(
  parameter int MAX_JOBS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  mlqs_pkg::req_t      req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output mlqs_pkg::rsp_t      rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADM   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_PICK  = 4'd3;
  localparam logic [3:0] S_RUN   = 4'd4;
  localparam logic [3:0] S_ADM2  = 4'd5;
  localparam logic [3:0] S_PUSH  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [15:0]   arr_q [MAX_JOBS];
  logic [7:0]    rem_q [MAX_JOBS];
  logic [1:0]    lvl_q [MAX_JOBS];
  logic [MAX_JOBS-1:0] queued_q;
  logic [IW-1:0] rrq_q [MAX_JOBS];
  logic [IW-1:0] head_q, tail_q;
  logic [CW-1:0] cnt_q, jobs_q;
  logic          act_q;
  logic [IW-1:0] rrjob_q;
  logic [7:0]    slice_q;
  logic [15:0]   now_q;
  logic [7:0]    quantum_q;
  logic [CW-1:0] idx_q;
  logic [1:0]    lvl_best_q;
  logic [7:0]    best2_q;
  logic [IW-1:0] sel2_q, sel3_q;
  logic          has2_q, has3_q;
  logic [IW-1:0] sel_q;
  logic          ran_q, fin_q, rrlvl_q, all_q;
  logic          rsp_valid_q;
  mlqs_pkg::rsp_t rsp_q;

  logic [IW-1:0] ix;
  logic          elig;
  logic [7:0]    rem_dec;

  assign ix      = idx_q[IW-1:0];
  assign elig    = (rem_q[ix] != 8'd0) && (arr_q[ix] <= now_q);
  assign rem_dec = rem_q[sel_q] - 8'd1;

  assign req_ready_o = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    wrap_inc = (32'(v) + 1 >= MAX_JOBS) ? '0 : IW'(32'(v) + 1);
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i && req_ready_o) begin
        state_d = (req_i.kind == mlqs_pkg::KIND_TICK) ? S_ADM : S_IDLE;
      end
      S_ADM:  if (idx_q >= jobs_q) state_d = S_SCAN;
      S_SCAN: if (idx_q >= jobs_q) state_d = S_PICK;
      S_PICK: state_d = S_RUN;
      S_RUN:  state_d = S_PUSH;
      S_PUSH: state_d = S_DONE;
      S_ADM2: if (idx_q >= jobs_q) state_d = S_PUSH;
      S_DONE: if (idx_q >= jobs_q) state_d = S_OUT;
      S_OUT:  if (!rsp_valid_q || rsp_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // After a round robin slice expires, admit new arrivals before requeueing.
    if (state_q == S_RUN && ran_q && rrlvl_q && rem_dec != 8'd0 && slice_q <= 8'd1) begin
      state_d = S_ADM2;
    end
    if (state_q == S_PUSH && !(ran_q && rrlvl_q && !fin_q && slice_q == 8'd0)) begin
      state_d = S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      queued_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      cnt_q <= '0;
      jobs_q <= '0;
      act_q <= 1'b0;
      rrjob_q <= '0;
      slice_q <= '0;
      now_q <= '0;
      quantum_q <= mlqs_pkg::QuantumReset;
      idx_q <= '0;
      rrlvl_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) quantum_q <= cfg_data_i;
      if (state_q == S_OUT && (!rsp_valid_q || rsp_ready_i)) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (req_valid_i && req_ready_o) begin
            if (req_i.kind == mlqs_pkg::KIND_LOAD) begin
              if (32'(jobs_q) < MAX_JOBS) begin
                queued_q[jobs_q[IW-1:0]] <= 1'b0;
                jobs_q <= jobs_q + 1'b1;
              end
            end else if (req_i.kind == mlqs_pkg::KIND_CLEAR) begin
              queued_q <= '0;
              head_q <= '0;
              tail_q <= '0;
              cnt_q <= '0;
              act_q <= 1'b0;
              rrjob_q <= '0;
              slice_q <= '0;
              jobs_q <= '0;
            end
          end
        end
        S_ADM, S_ADM2: begin
          if (idx_q < jobs_q) begin
            idx_q <= idx_q + 1'b1;
            if (lvl_q[ix] == 2'd1 && !queued_q[ix] && elig && 32'(cnt_q) < MAX_JOBS) begin
              tail_q <= wrap_inc(tail_q);
              cnt_q <= cnt_q + 1'b1;
              queued_q[ix] <= 1'b1;
            end
          end else begin
            idx_q <= '0;
          end
        end
        S_SCAN: begin
          if (idx_q < jobs_q) idx_q <= idx_q + 1'b1;
          else idx_q <= '0;
        end
        S_PICK: begin
          if (act_q || lvl_best_q == 2'd1) begin
            rrlvl_q <= 1'b1;
            if (!act_q && cnt_q != '0) begin
              rrjob_q <= rrq_q[head_q];
              head_q <= wrap_inc(head_q);
              cnt_q <= cnt_q - 1'b1;
              act_q <= 1'b1;
              slice_q <= (quantum_q == 8'd0) ? 8'd1 : quantum_q;
            end
          end else begin
            rrlvl_q <= 1'b0;
          end
        end
        S_RUN: begin
          if (ran_q) begin
            if (rrlvl_q) begin
              if (slice_q != 8'd0) slice_q <= slice_q - 8'd1;
              if (rem_dec == 8'd0) act_q <= 1'b0;
            end
          end
          if (now_q != 16'hFFFF) now_q <= now_q + 16'd1;
          idx_q <= '0;
        end
        S_PUSH: begin
          if (ran_q && rrlvl_q && !fin_q && slice_q == 8'd0) begin
            if (32'(cnt_q) < MAX_JOBS) begin
              tail_q <= wrap_inc(tail_q);
              cnt_q <= cnt_q + 1'b1;
            end
            act_q <= 1'b0;
          end
          idx_q <= '0;
        end
        S_DONE: begin
          if (idx_q < jobs_q) idx_q <= idx_q + 1'b1;
          else idx_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset: table contents, scan accumulators and the response register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i && req_ready_o &&
        req_i.kind == mlqs_pkg::KIND_LOAD && 32'(jobs_q) < MAX_JOBS) begin
      arr_q[jobs_q[IW-1:0]] <= req_i.arrival_time;
      rem_q[jobs_q[IW-1:0]] <= req_i.burst_time;
      lvl_q[jobs_q[IW-1:0]] <= (req_i.level == 2'd0) ? 2'd1 : req_i.level;
    end
    if ((state_q == S_ADM || state_q == S_ADM2) && idx_q < jobs_q &&
        lvl_q[ix] == 2'd1 && !queued_q[ix] && elig && 32'(cnt_q) < MAX_JOBS) begin
      rrq_q[tail_q] <= ix;
    end
    if (state_q == S_PUSH && ran_q && rrlvl_q && !fin_q && slice_q == 8'd0 &&
        32'(cnt_q) < MAX_JOBS) begin
      rrq_q[tail_q] <= rrjob_q;
    end
    if (state_q == S_ADM && idx_q >= jobs_q) begin
      lvl_best_q <= 2'd0;
      best2_q <= 8'hFF;
      has2_q <= 1'b0;
      has3_q <= 1'b0;
      sel2_q <= '0;
      sel3_q <= '0;
    end
    if (state_q == S_SCAN && idx_q < jobs_q && elig) begin
      if (lvl_best_q == 2'd0 || lvl_q[ix] < lvl_best_q) lvl_best_q <= lvl_q[ix];
      if (lvl_q[ix] == 2'd2 && (!has2_q || rem_q[ix] < best2_q)) begin
        best2_q <= rem_q[ix];
        sel2_q <= ix;
        has2_q <= 1'b1;
      end
      if (lvl_q[ix] == 2'd3 && !has3_q) begin
        sel3_q <= ix;
        has3_q <= 1'b1;
      end
    end
    if (state_q == S_PICK) begin
      if (act_q || lvl_best_q == 2'd1) begin
        if (act_q) begin
          sel_q <= rrjob_q;
          ran_q <= rem_q[rrjob_q] != 8'd0;
        end else begin
          sel_q <= rrq_q[head_q];
          ran_q <= (cnt_q != '0) && rem_q[rrq_q[head_q]] != 8'd0;
        end
      end else if (lvl_best_q == 2'd2) begin
        sel_q <= sel2_q;
        ran_q <= has2_q;
      end else if (lvl_best_q == 2'd3) begin
        sel_q <= sel3_q;
        ran_q <= has3_q;
      end else begin
        sel_q <= '0;
        ran_q <= 1'b0;
      end
    end
    if (state_q == S_RUN) begin
      fin_q <= ran_q && rem_dec == 8'd0;
      if (ran_q) rem_q[sel_q] <= rem_dec;
      all_q <= 1'b1;
    end
    if (state_q == S_DONE && idx_q < jobs_q && rem_q[ix] != 8'd0) all_q <= 1'b0;
    if (state_q == S_OUT && (!rsp_valid_q || rsp_ready_i)) begin
      rsp_q.slot_time <= now_q;
      rsp_q.job_index <= ran_q ? 4'(sel_q) : 4'd0;
      rsp_q.idle      <= !ran_q;
      rsp_q.finished  <= fin_q;
      rsp_q.all_done  <= all_q;
    end
  end

endmodule

// ===== sim/tb_multilevel_queue_scheduler.sv =====
// Testbench for the multilevel queue scheduler: random and directed requests checked against a predictor.
module tb_multilevel_queue_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int JOBS = 16;

  // Expected responses in order, plus a scheduler model that produces them.
  class sched_scoreboard;
    logic [15:0] arr_q[JOBS];
    logic [7:0]  rem_q[JOBS];
    logic [1:0]  lvl_q[JOBS];
    bit          queued[JOBS];
    logic [3:0]  rr_fifo[JOBS];
    int          rr_head, rr_tail, rr_count;
    bit          rr_active;
    int          rr_job, slice_left;
    int          now_t, job_count;
    logic [7:0]  quantum;
    mlqs_pkg::rsp_t expected_q[$];
    int          errors;
    int          ticks_seen, finishes_seen, idles_seen;

    function void clear_jobs();
      for (int i = 0; i < JOBS; i++) begin
        queued[i] = 0;
        rem_q[i] = '0;
      end
      rr_head = 0;
      rr_tail = 0;
      rr_count = 0;
      rr_active = 0;
      rr_job = 0;
      slice_left = 0;
      job_count = 0;
    endfunction

    function void reset_state();
      clear_jobs();
      now_t = 0;
      quantum = mlqs_pkg::QuantumReset;
      errors = 0;
    endfunction

    function void push_rr(int j);
      if (rr_count < JOBS) begin
        rr_fifo[rr_tail] = j[3:0];
        rr_tail = (rr_tail + 1) % JOBS;
        rr_count++;
      end
    endfunction

    function void admit_level_one();
      for (int i = 0; i < job_count; i++) begin
        if (lvl_q[i] == 2'd1 && !queued[i] && rem_q[i] > 0 && arr_q[i] <= now_t) begin
          push_rr(i);
          queued[i] = 1;
        end
      end
    endfunction

    function void note_request(mlqs_pkg::req_t r);
      int   win_lvl, sel, best;
      bit   ran, fin, all;
      mlqs_pkg::rsp_t rsp;
      win_lvl = 4;
      sel = 0;
      ran = 0;
      fin = 0;
      all = 1;
      if (r.kind == mlqs_pkg::KIND_LOAD) begin
        if (job_count < JOBS) begin
          arr_q[job_count] = r.arrival_time;
          rem_q[job_count] = r.burst_time;
          lvl_q[job_count] = (r.level == 2'd0) ? 2'd1 : r.level;
          queued[job_count] = 0;
          job_count++;
        end
        return;
      end
      if (r.kind == mlqs_pkg::KIND_CLEAR) begin
        clear_jobs();
        return;
      end
      if (r.kind != mlqs_pkg::KIND_TICK) return;
      admit_level_one();
      for (int i = 0; i < job_count; i++)
        if (rem_q[i] > 0 && arr_q[i] <= now_t && lvl_q[i] < win_lvl) win_lvl = lvl_q[i];
      if (rr_active) win_lvl = 1;
      if (win_lvl == 1) begin
        if (!rr_active && rr_count > 0) begin
          rr_job = rr_fifo[rr_head];
          rr_head = (rr_head + 1) % JOBS;
          rr_count--;
          rr_active = 1;
          slice_left = (quantum == 0) ? 1 : quantum;
        end
        if (rr_active && rem_q[rr_job] > 0) begin
          sel = rr_job;
          ran = 1;
        end
      end else if (win_lvl == 2) begin
        best = 256;
        for (int i = 0; i < job_count; i++)
          if (lvl_q[i] == 2'd2 && rem_q[i] > 0 && arr_q[i] <= now_t && rem_q[i] < best) begin
            best = rem_q[i];
            sel = i;
            ran = 1;
          end
      end else if (win_lvl == 3) begin
        for (int i = 0; i < job_count; i++)
          if (!ran && lvl_q[i] == 2'd3 && rem_q[i] > 0 && arr_q[i] <= now_t) begin
            sel = i;
            ran = 1;
          end
      end
      if (ran) begin
        rem_q[sel]--;
        fin = (rem_q[sel] == 0);
      end
      if (now_t < 16'hFFFF) now_t++;
      if (ran && win_lvl == 1) begin
        if (slice_left > 0) slice_left--;
        if (fin) begin
          rr_active = 0;
        end else if (slice_left == 0) begin
          admit_level_one();
          push_rr(rr_job);
          rr_active = 0;
        end
      end
      for (int i = 0; i < job_count; i++)
        if (rem_q[i] > 0) all = 0;
      rsp.slot_time = now_t[15:0];
      rsp.job_index = ran ? sel[3:0] : 4'd0;
      rsp.idle = !ran;
      rsp.finished = fin;
      rsp.all_done = all;
      expected_q.push_back(rsp);
    endfunction

    task report_mismatch(string what, mlqs_pkg::rsp_t exp_rsp, mlqs_pkg::rsp_t got);
      $display("MISMATCH %s: expected %h got %h at %0t", what, exp_rsp, got, $realtime);
      errors++;
    endtask

    task check_response(mlqs_pkg::rsp_t got);
      mlqs_pkg::rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        report_mismatch("response with nothing expected", '0, got);
        return;
      end
      exp_rsp = expected_q.pop_front();
      ticks_seen++;
      if (got.finished) finishes_seen++;
      if (got.idle) idles_seen++;
      if (got.slot_time !== exp_rsp.slot_time) report_mismatch("slot_time", exp_rsp, got);
      if (got.job_index !== exp_rsp.job_index) report_mismatch("job_index", exp_rsp, got);
      if (got.idle !== exp_rsp.idle) report_mismatch("idle", exp_rsp, got);
      if (got.finished !== exp_rsp.finished) report_mismatch("finished", exp_rsp, got);
      if (got.all_done !== exp_rsp.all_done) report_mismatch("all_done", exp_rsp, got);
    endtask
  endclass

  logic           clk_i = 0;
  logic           rst_ni = 0;
  logic           req_valid_i = 0;
  logic           req_ready_o;
  mlqs_pkg::req_t req_i = '0;
  logic           rsp_valid_o;
  logic           rsp_ready_i = 0;
  mlqs_pkg::rsp_t rsp_o;
  logic           cfg_valid_i = 0;
  logic           cfg_ready_o;
  logic [7:0]     cfg_data_i = '0;

  sched_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  int req_count;

  multilevel_queue_scheduler #(.MAX_JOBS(JOBS)) u_top (.*);

  always #6 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off when asked.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready_i <= 0;
    end else begin
      rsp_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) sb.check_response(rsp_o);
  end

  // Valid stays up after an accepted request only when the next one follows at once.
  task automatic send_request(mlqs_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 0;
      @(negedge clk_i);
    end
    req_valid_i <= 1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(r);
    req_count++;
    @(negedge clk_i);
  endtask

  task automatic send_job(int arr, int burst, int lvl);
    mlqs_pkg::req_t r;
    r.kind = mlqs_pkg::KIND_LOAD;
    r.arrival_time = arr[15:0];
    r.burst_time = burst[7:0];
    r.level = lvl[1:0];
    send_request(r);
  endtask

  task automatic send_cmd(mlqs_pkg::kind_e k);
    mlqs_pkg::req_t r;
    r = '0;
    r.kind = k;
    r.arrival_time = 16'($urandom);
    r.burst_time = 8'($urandom);
    r.level = 2'($urandom);
    send_request(r);
  endtask

  task automatic wait_drained();
    req_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (3 * JOBS + 20) @(negedge clk_i);
  endtask

  task automatic write_quantum(logic [7:0] q);
    wait_drained();
    cfg_valid_i <= 1;
    cfg_data_i <= q;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.quantum = q;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // One scenario: clear, load jobs in mostly rising arrival order, then tick, mixing in stray requests.
  task automatic run_scenario(int n_jobs, int max_burst);
    int arr;
    int base;
    base = sb.now_t;
    arr = base + $urandom_range(3);
    send_cmd(mlqs_pkg::KIND_CLEAR);
    for (int j = 0; j < n_jobs; j++) begin
      if ($urandom_range(9) == 0) send_job($urandom, $urandom, $urandom);
      else send_job(arr, $urandom_range(max_burst), $urandom_range(3));
      arr += $urandom_range(4);
      if (arr > 65535) arr = 65535;
    end
    for (int t = 0; t < 4 * n_jobs + $urandom_range(6); t++) begin
      if ($urandom_range(30) == 0) send_cmd(mlqs_pkg::KIND_NONE);
      else if ($urandom_range(60) == 0) send_job(sb.now_t, $urandom_range(4), $urandom_range(3));
      send_cmd(mlqs_pkg::KIND_TICK);
    end
  endtask

  initial begin
    #20ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    send_idle_pct = 31;
    recv_idle_pct = 64;
    hold_off = 0;
    req_count = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: all levels, zero burst, level zero, ties, full table, unknown kind.
    send_job(0, 3, 1);
    send_job(0, 2, 1);
    send_job(0, 0, 2);
    send_job(1, 2, 2);
    send_job(1, 2, 2);
    send_job(2, 255, 3);
    send_job(3, 1, 0);
    send_job(65535, 1, 3);
    send_cmd(mlqs_pkg::KIND_NONE);
    repeat (12) send_cmd(mlqs_pkg::KIND_TICK);
    send_cmd(mlqs_pkg::KIND_CLEAR);
    for (int j = 0; j < JOBS + 2; j++) send_job(sb.now_t, 1, 3);
    repeat (3) send_cmd(mlqs_pkg::KIND_TICK);

    write_quantum(8'd0);
    for (int s = 0; s < 10; s++) run_scenario($urandom_range(2, 8), 6);
    write_quantum(8'd255);
    for (int s = 0; s < 6; s++) run_scenario($urandom_range(2, JOBS), 4);

    // Long receiver hold-off while requests keep coming.
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk_i);
        hold_off = 0;
      end
      run_scenario(4, 3);
    join

    write_quantum(8'd1);
    send_idle_pct = 64;
    recv_idle_pct = 31;
    for (int s = 0; s < 10; s++) run_scenario($urandom_range(2, 8), 6);
    // Sender pauses until every expected response is back.
    req_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    write_quantum(8'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int s = 0; s < 4; s++) run_scenario($urandom_range(2, JOBS), 5);
    write_quantum(8'($urandom_range(1, 254)));
    for (int s = 0; s < 6; s++) run_scenario($urandom_range(2, 8), 3);
    // Load a job that arrives near the top of the time range, then tick.
    send_cmd(mlqs_pkg::KIND_CLEAR);
    send_job(65530, 20, 1);
    repeat (12) send_cmd(mlqs_pkg::KIND_TICK);

    wait_drained();
    $display("Covered %0d requests, %0d ticks, %0d finishes, %0d idle ticks.",
             req_count, sb.ticks_seen, sb.finishes_seen, sb.idles_seen);
    $display("Quantum settings 0, 1, 2, 3, 255 and random; stalls on both sides.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
